>>> hdl/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
package pcbp_pkg;

  localparam int DEF_MAX_CODE_LENGTH = 32;
  localparam int DEF_SYMBOL_COUNT    = 256;

  localparam int KIND_W   = 2;
  localparam int SYM_IN_W = 8;
  localparam int LEN_IN_W = 6;
  localparam int CODE_IN_W = 32;
  localparam int BYTE_W   = 8;
  localparam int VALID_W  = 4;
  localparam int PEND_W   = 7;
  localparam int CNT_W    = 3;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic tbl_wr;
    logic tbl_rd;
    logic acc_load;
    logic byte_emit;
    logic flush_emit;
    logic pend_commit;
    logic pend_clear;
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic out_free;
    logic total_ge8;
    logic pend_nonzero;
  } stat_t;

endpackage

>>> hdl/pcbp_ctrl.sv
// Sequencer for the bit packer: decodes transactions and steps the datapath.
module pcbp_ctrl
  import pcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_stall,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_acc = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_ENCODE && stat.sym_ok) begin
            state_nxt = ST_READ;
          end else if (in_kind == KIND_FLUSH) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_READ:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!stat.total_ge8) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_nonzero || stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.tbl_wr  = in_acc && (in_kind == KIND_LOAD) && stat.sym_ok;
        cmd.tbl_rd  = in_acc && (in_kind == KIND_ENCODE) && stat.sym_ok;
      end
      ST_READ: begin
        cmd.acc_load = 1'b1;
      end
      ST_EMIT: begin
        if (!stat.total_ge8) begin
          cmd.pend_commit = 1'b1;
        end else begin
          cmd.byte_emit = stat.out_free;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_nonzero) begin
          cmd.pend_clear = 1'b1;
        end else begin
          cmd.flush_emit = stat.out_free;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/pcbp_dp.sv
// Datapath: code table, bit accumulator, pending bits and output register.
module pcbp_dp
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = DEF_SYMBOL_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SYM_IN_W-1:0]  in_symbol,
  input  logic [LEN_IN_W-1:0]  in_code_length,
  input  logic [CODE_IN_W-1:0] in_code_bits,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [VALID_W-1:0]   out_valid_bits,
  output logic                 out_last_of_run,
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int EFF_LEN = (MAX_CODE_LENGTH > CODE_IN_W) ? CODE_IN_W : MAX_CODE_LENGTH;
  localparam int LEN_W   = $clog2(EFF_LEN + 1);
  localparam int ENT_W   = LEN_W + EFF_LEN;
  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int ACC_W   = EFF_LEN + PEND_W;
  localparam int TOT_W   = $clog2(ACC_W + 1);

  logic [ENT_W-1:0]   tbl_mem [SYMBOL_COUNT];
  logic [ENT_W-1:0]   rd_data_r;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [PEND_W-1:0]  pend_bits_r;
  logic [CNT_W-1:0]   pend_cnt_r;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [VALID_W-1:0] out_vbits_r;
  logic               out_last_r;

  logic [LEN_IN_W:0]  wr_len_ext;
  logic [LEN_W-1:0]   wr_len;
  logic [EFF_LEN-1:0] wr_code;
  logic [LEN_W-1:0]   rd_len_raw;
  logic [LEN_W-1:0]   clen;
  logic [EFF_LEN-1:0] rd_code;
  logic [BYTE_W-1:0]  emit_byte;
  logic [BYTE_W-1:0]  flush_byte;
  logic [PEND_W-1:0]  pend_mask;
  logic               out_load;

  // load path: saturate length, keep only the low length bits of the code
  always_comb begin
    wr_len_ext = {1'b0, in_code_length};
    if (wr_len_ext > (LEN_IN_W+1)'(EFF_LEN)) begin
      wr_len_ext = (LEN_IN_W+1)'(EFF_LEN);
    end
    wr_len  = LEN_W'(wr_len_ext);
    wr_code = EFF_LEN'(in_code_bits & CODE_IN_W'((65'd1 << wr_len_ext) - 65'd1));
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[in_symbol[SYM_W-1:0]] <= {wr_len, wr_code};
    end
    if (cmd.tbl_rd) begin
      rd_data_r <= tbl_mem[in_symbol[SYM_W-1:0]];
    end
  end

  assign rd_len_raw = rd_data_r[ENT_W-1 -: LEN_W];
  assign rd_code    = rd_data_r[EFF_LEN-1:0];
  assign clen       = (rd_len_raw > LEN_W'(EFF_LEN)) ? LEN_W'(EFF_LEN) : rd_len_raw;

  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = total_r;
    if (cmd.acc_load) begin
      acc_nxt   = (ACC_W'(pend_bits_r) << clen) | ACC_W'(rd_code);
      total_nxt = TOT_W'(pend_cnt_r) + TOT_W'(clen);
    end else if (cmd.byte_emit) begin
      total_nxt = total_r - TOT_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
  end

  assign emit_byte  = BYTE_W'(acc_r >> (total_r - TOT_W'(BYTE_W)));
  assign flush_byte = BYTE_W'(BYTE_W'(pend_bits_r) << (VALID_W'(BYTE_W) - VALID_W'(pend_cnt_r)));
  assign pend_mask  = PEND_W'((8'd1 << total_r[CNT_W-1:0]) - 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (cmd.pend_commit) begin
      pend_bits_r <= PEND_W'(acc_r) & pend_mask;
      pend_cnt_r  <= total_r[CNT_W-1:0];
    end else if (cmd.pend_clear || cmd.flush_emit) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end
  end

  // output register, refilled when empty or when the current transaction leaves
  assign out_load = cmd.byte_emit || cmd.flush_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_emit) begin
      out_byte_r  <= emit_byte;
      out_vbits_r <= VALID_W'(BYTE_W);
      // last byte when fewer than eight bits remain behind it
      out_last_r  <= ((total_r - TOT_W'(BYTE_W)) < TOT_W'(BYTE_W));
    end else if (cmd.flush_emit) begin
      out_byte_r  <= flush_byte;
      out_vbits_r <= VALID_W'(pend_cnt_r);
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_valid_bits  = out_vbits_r;
  assign out_last_of_run = out_last_r;

  assign stat.sym_ok       = ({1'b0, in_symbol} < (SYM_IN_W+1)'(SYMBOL_COUNT));
  assign stat.out_free     = !out_valid_r || !out_stall;
  assign stat.total_ge8    = (total_r >= TOT_W'(BYTE_W));
  assign stat.pend_nonzero = (pend_cnt_r != '0);

endmodule

>>> hdl/prefix_code_bit_packer_unit.sv
// Top level of the prefix code bit packer: sequencer plus datapath.
//
//   channel | ports                                        | handshake
//   input   | in_kind, in_symbol, in_code_length, in_code_bits | in_valid / in_stall
//   result  | out_byte, out_valid_bits, out_last_of_run     | out_valid / out_stall
//
// Load and ignored transactions complete in the idle state. Encode: table read,
// accumulate, one byte per cycle while the output is free, then pending update.
// Flush pads out pending bits. The single-byte output register sets the byte rate.
// Reset clears pending bits and control; the code table is undefined until loaded.
// A stalled result holds the output register; input is still taken while idle.
module prefix_code_bit_packer_unit
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = DEF_SYMBOL_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [SYM_IN_W-1:0]  in_symbol,
  input  logic [LEN_IN_W-1:0]  in_code_length,
  input  logic [CODE_IN_W-1:0] in_code_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [VALID_W-1:0]   out_valid_bits,
  output logic                 out_last_of_run
);

  cmd_t  cmd;
  stat_t stat;

  pcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcbp_dp #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .SYMBOL_COUNT    (SYMBOL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol       (in_symbol),
    .in_code_length  (in_code_length),
    .in_code_bits    (in_code_bits),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_valid_bits  (out_valid_bits),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

>>> tb/tb_prefix_code_bit_packer_unit.sv
// Testbench for the prefix code bit packer: directed and random code streams, checked per byte.
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer_unit;
  import pcbp_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_SPACING  = 210;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 215;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_BYTES     = 4;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [SYM_IN_W-1:0]  symbol;
    logic [LEN_IN_W-1:0]  len;
    logic [CODE_IN_W-1:0] bits;
    bit                   wait_empty;
  } code_item_t;

  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic [VALID_W-1:0] nbits;
    logic               last;
  } packed_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [SYM_IN_W-1:0]  in_symbol = '0;
  logic [LEN_IN_W-1:0]  in_code_length = '0;
  logic [CODE_IN_W-1:0] in_code_bits = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic [VALID_W-1:0]   out_valid_bits;
  logic                 out_last_of_run;

  // stimulus side
  code_item_t code_stream_q[$];
  bit         gen_loaded[256];
  int         loaded_syms[$];

  // predictor state
  logic [LEN_IN_W-1:0]  code_len_tbl[256];
  logic [CODE_IN_W-1:0] code_bits_tbl[256];
  logic [PEND_W-1:0]    tail_bits = '0;
  logic [CNT_W-1:0]     tail_count = '0;
  packed_byte_t         packed_byte_q[$];

  bit in_taken = 1'b0;
  int send_gap = 0;
  int burst_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  int hold_left = 0;
  int next_hold_at = 40;
  int cycle_cnt = 0;

  int n_loads = 0, n_encodes = 0, n_flushes = 0, n_ignored = 0;
  int bytes_checked = 0, byte_mismatches = 0, stray_bytes = 0, fail_reports = 0;
  int n_holds = 0, n_drains = 0;

  prefix_code_bit_packer_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_symbol      (in_symbol),
    .in_code_length (in_code_length),
    .in_code_bits   (in_code_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid_bits (out_valid_bits),
    .out_last_of_run(out_last_of_run)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 68) return $urandom_range(1, 10);
    if (r < 90) return $urandom_range(11, 32);
    return $urandom_range(33, 63);
  endfunction

  function automatic void push_item(input logic [KIND_W-1:0] kind, input int sym, input int len,
                                    input logic [CODE_IN_W-1:0] bits, input bit drain);
    code_item_t it;
    it.kind = kind;
    it.symbol = 8'(sym);
    it.len = 6'(len);
    it.bits = bits;
    it.wait_empty = drain;
    code_stream_q.push_back(it);
    if (kind == KIND_LOAD && !gen_loaded[sym & 8'hFF]) begin
      gen_loaded[sym & 8'hFF] = 1'b1;
      loaded_syms.push_back(sym & 8'hFF);
    end
  endfunction

  // Bit packer predictor: updates the code table and the tail bits, queues the bytes.
  function automatic void pack_code_item(input logic [KIND_W-1:0] kind,
                                         input logic [SYM_IN_W-1:0] sym,
                                         input logic [LEN_IN_W-1:0] len,
                                         input logic [CODE_IN_W-1:0] bits);
    int           clen;
    int           lim;
    int           total;
    int           emitted;
    logic [63:0]  acc;
    packed_byte_t b;
    lim = (DEF_MAX_CODE_LENGTH < 32) ? DEF_MAX_CODE_LENGTH : 32;
    case (kind)
      KIND_LOAD: begin
        n_loads++;
        clen = (int'(len) > lim) ? lim : int'(len);
        code_len_tbl[sym] = 6'(clen);
        code_bits_tbl[sym] = 32'(64'(bits) & ((64'd1 << clen) - 64'd1));
      end
      KIND_ENCODE: begin
        n_encodes++;
        clen = int'(code_len_tbl[sym]);
        acc = (64'(tail_bits) << clen) | (64'(code_bits_tbl[sym]) & ((64'd1 << clen) - 64'd1));
        total = int'(tail_count) + clen;
        emitted = 0;
        while (total >= BYTE_W && emitted < MAX_BYTES) begin
          total -= BYTE_W;
          b.data = 8'(acc >> total);
          b.nbits = 4'(BYTE_W);
          b.last = (total < BYTE_W) || (emitted == MAX_BYTES - 1);
          packed_byte_q.push_back(b);
          emitted++;
        end
        tail_count = 3'(total);
        tail_bits = 7'(acc & ((64'd1 << tail_count) - 64'd1));
      end
      KIND_FLUSH: begin
        n_flushes++;
        if (tail_count != 0) begin
          // pad on the right with zeros
          b.data = 8'(16'(tail_bits) << (BYTE_W - int'(tail_count)));
          b.nbits = 4'(tail_count);
          b.last = 1'b1;
          packed_byte_q.push_back(b);
        end
        tail_bits = '0;
        tail_count = '0;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Driver: presents the next code item at the falling edge.
  always @(negedge clk) begin
    code_item_t nxt;
    int         r;
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (code_stream_q.size() != 0 &&
                   (!code_stream_q[0].wait_empty || packed_byte_q.size() == 0)) begin
        nxt = code_stream_q.pop_front();
        if (nxt.wait_empty) n_drains++;
        in_kind <= nxt.kind;
        in_symbol <= nxt.symbol;
        in_code_length <= nxt.len;
        in_code_bits <= nxt.bits;
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
          send_gap <= 0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) burst_left <= 40;
          send_gap <= (r < 50) ? 0 : pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, triggered by the number of bytes seen so far.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && bytes_checked >= next_hold_at) begin
      hold_left <= LONG_HOLD;
      next_hold_at <= next_hold_at + HOLD_SPACING;
      n_holds++;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm_left <= 40;
        out_stall <= 1'b0;
      end else if (r < 30) begin
        out_stall <= 1'b1;
        stall_left <= pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input transaction, checks each output transaction.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      pack_code_item(in_kind, in_symbol, in_code_length, in_code_bits);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (packed_byte_q.size() == 0) begin
        stray_bytes++;
        fail_reports++;
        if (fail_reports <= MAX_REPORTS)
          $display("unexpected byte %h bits %0d last %b", out_byte, out_valid_bits,
                   out_last_of_run);
      end else begin
        want = packed_byte_q.pop_front();
        bytes_checked++;
        if (out_byte !== want.data || out_valid_bits !== want.nbits ||
            out_last_of_run !== want.last) begin
          byte_mismatches++;
          fail_reports++;
          if (fail_reports <= MAX_REPORTS)
            $display("byte %0d mismatch: exp %h bits %0d last %b, got %h bits %0d last %b",
                     bytes_checked, want.data, want.nbits, want.last,
                     out_byte, out_valid_bits, out_last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb_prefix_code_bit_packer_unit: FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int counted;
    bit drain;

    // directed: empty, full-width, saturated and masked codes, flush corners, unused kind
    push_item(KIND_LOAD, 0, 0, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_LOAD, 255, 32, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_LOAD, 1, 1, 32'h0000_0001, 1'b0);
    push_item(KIND_LOAD, 2, 63, 32'hA5A5_A5A5, 1'b0);
    push_item(KIND_LOAD, 3, 33, 32'h1234_5678, 1'b0);
    push_item(KIND_LOAD, 170, 8, 32'hFFFF_FF5A, 1'b0);
    push_item(KIND_LOAD, 85, 7, 32'h0000_0055, 1'b0);
    push_item(KIND_ENCODE, 255, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 1, 63, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_ENCODE, 0, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 2, 0, 32'h0, 1'b0);
    push_item(KIND_FLUSH, 0, 0, 32'h0, 1'b0);
    push_item(KIND_FLUSH, 255, 63, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_UNUSED, 255, 63, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_ENCODE, 85, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 255, 0, 32'h0, 1'b0);
    push_item(KIND_FLUSH, 0, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 170, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 3, 0, 32'h0, 1'b0);
    push_item(KIND_UNUSED, 0, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 85, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 1, 0, 32'h0, 1'b0);
    push_item(KIND_LOAD, 255, 0, 32'h0, 1'b0);
    push_item(KIND_ENCODE, 255, 0, 32'h0, 1'b0);
    push_item(KIND_FLUSH, 0, 0, 32'h0, 1'b1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      drain = (counted % 70 == 69);
      if (r < 12) begin
        push_item(KIND_LOAD, $urandom_range(0, 255), pick_len(), $urandom, drain);
        counted++;
      end else if (r < 82) begin
        push_item(KIND_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  $urandom_range(0, 63), $urandom, drain);
        counted++;
      end else if (r < 95) begin
        push_item(KIND_FLUSH, $urandom_range(0, 255), $urandom_range(0, 63), $urandom, drain);
        counted++;
      end else begin
        push_item(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 63), $urandom, 1'b0);
      end
    end
    push_item(KIND_FLUSH, 0, 0, 32'h0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (code_stream_q.size() != 0 || in_valid || packed_byte_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored transactions;",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("%0d bytes checked, receiver hold-offs %0d, sender drain pauses %0d,",
             bytes_checked, n_holds, n_drains);
    $display("mismatches %0d, unexpected bytes %0d.", byte_mismatches, stray_bytes);
    if (byte_mismatches == 0 && stray_bytes == 0 && packed_byte_q.size() == 0)
      $display("tb_prefix_code_bit_packer_unit: PASS");
    else
      $display("tb_prefix_code_bit_packer_unit: FAIL");
    $finish;
  end

endmodule
